// ----- rtl/pwpc_pkg.sv -----
// Shared types, constants and saturating helpers for the piecewise polynomial calibration block.
`timescale 1ns / 1ps

package pwpc_pkg;

    // Value format: signed two's complement with a configurable number of fraction bits.
    localparam int VAL_W = 56;
    localparam int HALF_W = VAL_W / 2;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_SEGMENTS = 4;
    localparam int DEF_MAX_COEFFS   = 4;
    localparam int DEF_NEWTON_ITERS = 20;
    localparam int DEF_FRAC_BITS    = 24;

    // Command codes carried with each input item.
    localparam logic [1:0] CMD_LOAD_COEFF = 2'd0;
    localparam logic [1:0] CMD_LOAD_BOUND = 2'd1;
    localparam logic [1:0] CMD_CH_TO_EN   = 2'd2;
    localparam logic [1:0] CMD_EN_TO_CH   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_LIMIT      = 2'd1;
    localparam logic [1:0] STATUS_ZERO_DERIV = 2'd2;

    // Configuration register indexes.
    localparam logic REG_ENABLE    = 1'b0;
    localparam logic REG_SEG_COUNT = 1'b1;

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Operation request to one of the multi-cycle arithmetic units.
    typedef struct packed {
        logic start;
        val_t a;
        val_t b;
    } op_req_t;

    // Saturating addition.
    function automatic val_t sat_add(val_t a, val_t b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
            return s[VAL_W] ? VAL_MIN : VAL_MAX;
        return s[VAL_W-1:0];
    endfunction

    // Saturating subtraction.
    function automatic val_t sat_sub(val_t a, val_t b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
            return s[VAL_W] ? VAL_MIN : VAL_MAX;
        return s[VAL_W-1:0];
    endfunction

    // Magnitude of a value as an unsigned word; the most negative value maps to 2^(VAL_W-1).
    function automatic logic [VAL_W-1:0] mag(val_t a);
        return a[VAL_W-1] ? (~a + 1'b1) : a;
    endfunction

endpackage

// ----- rtl/pwpc_mul.sv -----
// Multi-cycle saturating fixed-point multiplier built from four half-width partial products.
`timescale 1ns / 1ps

module pwpc_mul #(
    parameter int FRAC_BITS = pwpc_pkg::DEF_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pwpc_pkg::op_req_t req,
    output logic              done,
    output pwpc_pkg::val_t    prod
);

    localparam int W  = pwpc_pkg::VAL_W;
    localparam int H  = pwpc_pkg::HALF_W;
    localparam int PW = 2 * W;

    logic          busy_reg, busy_next;
    logic          fin_reg, fin_next;
    logic [1:0]    step_reg, step_next;
    logic          done_reg, done_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  ua_reg, ua_next;
    logic [W-1:0]  ub_reg, ub_next;
    logic [PW-1:0] acc_reg, acc_next;
    pwpc_pkg::val_t prod_reg, prod_next;

    logic [H-1:0]   a_part, b_part;
    logic [2*H-1:0] pp;
    logic [PW-1:0]  pp_sh;
    logic [PW-1:0]  rnd;
    logic [PW-1:0]  q;
    logic [W-1:0]   lim;

    // One partial product per cycle, placed at its weight.
    always_comb
    begin
        a_part = step_reg[1] ? ua_reg[W-1:H] : ua_reg[H-1:0];
        b_part = step_reg[0] ? ub_reg[W-1:H] : ub_reg[H-1:0];
        pp     = (2*H)'(a_part) * (2*H)'(b_part);
        unique case (step_reg)
            2'd0:    pp_sh = PW'(pp);
            2'd1,
            2'd2:    pp_sh = PW'(pp) << H;
            default: pp_sh = PW'(pp) << (2 * H);
        endcase
    end

    // Round to nearest, ties away from zero, then saturate to the value range.
    always_comb
    begin
        rnd = acc_reg + (PW'(1) << (FRAC_BITS - 1));
        q   = rnd >> FRAC_BITS;
        lim = neg_reg ? (W'(1) << (W - 1)) : {1'b0, {(W-1){1'b1}}};
    end

    // Sequencing of the accumulation.
    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = fin_reg;
        step_next = step_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        ua_next   = ua_reg;
        ub_next   = ub_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                fin_next  = 1'b0;
                step_next = 2'd0;
                neg_next  = req.a[W-1] ^ req.b[W-1];
                ua_next   = pwpc_pkg::mag(req.a);
                ub_next   = pwpc_pkg::mag(req.b);
                acc_next  = '0;
            end
        end
        else if (!fin_reg)
        begin
            acc_next = acc_reg + pp_sh;
            if (step_reg == 2'd3)
                fin_next = 1'b1;
            else
                step_next = step_reg + 2'd1;
        end
        else
        begin
            if (q > PW'(lim))
                prod_next = neg_reg ? pwpc_pkg::VAL_MIN : pwpc_pkg::VAL_MAX;
            else if (neg_reg)
                prod_next = -q[W-1:0];
            else
                prod_next = q[W-1:0];
            done_next = 1'b1;
            busy_next = 1'b0;
            fin_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ----- rtl/pwpc_div.sv -----
// Bit-serial restoring fixed-point divider with round-to-nearest and saturation.
`timescale 1ns / 1ps

module pwpc_div #(
    parameter int FRAC_BITS = pwpc_pkg::DEF_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pwpc_pkg::op_req_t req,
    output logic              done,
    output pwpc_pkg::val_t    quot
);

    localparam int W     = pwpc_pkg::VAL_W;
    localparam int NUM_W = W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [W-1:0]     ub_reg, ub_next;
    logic [W-1:0]     r_reg, r_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] q_reg, q_next;
    pwpc_pkg::val_t   quot_reg, quot_next;

    logic [W:0]       r_sh;
    logic             ge;
    logic             round_up;
    logic [NUM_W:0]   qr;
    logic [W-1:0]     lim;

    // One quotient bit per cycle.
    always_comb
    begin
        r_sh     = {r_reg, num_reg[NUM_W-1]};
        ge       = r_sh >= {1'b0, ub_reg};
        round_up = {r_reg, 1'b0} >= {1'b0, ub_reg};
        qr       = (NUM_W + 1)'(q_reg) + (NUM_W + 1)'(round_up);
        lim      = neg_reg ? (W'(1) << (W - 1)) : {1'b0, {(W-1){1'b1}}};
    end

    // Sequencing of the division.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        ub_next   = ub_reg;
        r_next    = r_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        quot_next = quot_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                cnt_next  = CNT_W'(NUM_W);
                neg_next  = req.a[W-1] ^ req.b[W-1];
                ub_next   = pwpc_pkg::mag(req.b);
                num_next  = NUM_W'(pwpc_pkg::mag(req.a)) << FRAC_BITS;
                r_next    = '0;
                q_next    = '0;
            end
        end
        else if (cnt_reg != '0)
        begin
            r_next   = ge ? W'(r_sh - {1'b0, ub_reg}) : r_sh[W-1:0];
            num_next = num_reg << 1;
            q_next   = {q_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
        else
        begin
            if (qr > (NUM_W + 1)'(lim))
                quot_next = neg_reg ? pwpc_pkg::VAL_MIN : pwpc_pkg::VAL_MAX;
            else if (neg_reg)
                quot_next = -qr[W-1:0];
            else
                quot_next = qr[W-1:0];
            done_next = 1'b1;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        ub_reg   <= ub_next;
        r_reg    <= r_next;
        num_reg  <= num_next;
        q_reg    <= q_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/piecewise_poly_calibration_top.sv -----
// Top level of the piecewise polynomial calibration block: tables, sequencer and output register.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  tuser: command; tdata: segment, coefficient, count, operand
//  m_*      out        m_tvalid/m_tready  tuser: status; tdata: result value
//  cfg_*    in         cfg_we             cfg_index selects the register, cfg_data is written
//
// Loads and pass-through results go straight to the done state. A forward conversion scans
// up to MAX_SEGMENTS segments and then takes Horner steps in the shared multiplier. An inverse
// adds one Horner evaluation per scanned segment, a guess division and per Newton step two
// multiplies per Horner step plus one such division, for up to NEWTON_ITERS Newton steps.
// Reset clears the control state, the counts and the configuration registers; coefficients,
// bounds and payload registers are not cleared. A new item is taken while a finished result
// waits; the next result then holds.
`timescale 1ns / 1ps

module piecewise_poly_calibration_top #(
    parameter int MAX_SEGMENTS = pwpc_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_COEFFS   = pwpc_pkg::DEF_MAX_COEFFS,
    parameter int NEWTON_ITERS = pwpc_pkg::DEF_NEWTON_ITERS,
    parameter int FRAC_BITS    = pwpc_pkg::DEF_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // segment_index[1:0], coeff_index[3:2], coeff_count[6:4],
                                   // operand_value[62:7], zero pad [63]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // result_value[55:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data
);

    localparam int W      = pwpc_pkg::VAL_W;
    localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int COEF_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int TBL_D  = MAX_SEGMENTS * MAX_COEFFS;
    localparam int TBL_W  = (TBL_D > 1) ? $clog2(TBL_D) : 1;
    localparam int CNT_W  = $clog2(MAX_COEFFS + 1);
    localparam int NS_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int IT_W   = $clog2(NEWTON_ITERS + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN      = 4'd1;
    localparam logic [3:0] S_H_START   = 4'd2;
    localparam logic [3:0] S_H_DMUL    = 4'd3;
    localparam logic [3:0] S_H_DWAIT   = 4'd4;
    localparam logic [3:0] S_H_PMUL    = 4'd5;
    localparam logic [3:0] S_H_PWAIT   = 4'd6;
    localparam logic [3:0] S_H_END     = 4'd7;
    localparam logic [3:0] S_PICK      = 4'd8;
    localparam logic [3:0] S_GUESS     = 4'd9;
    localparam logic [3:0] S_GUESS_WT  = 4'd10;
    localparam logic [3:0] S_CHECK     = 4'd11;
    localparam logic [3:0] S_NDIV_WT   = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    // What follows a polynomial evaluation.
    localparam logic [1:0] AF_FWD    = 2'd0;
    localparam logic [1:0] AF_SEL    = 2'd1;
    localparam logic [1:0] AF_NEWTON = 2'd2;

    // Input field unpacking.
    logic [1:0]     in_seg;
    logic [1:0]     in_ci;
    logic [2:0]     in_cnt;
    pwpc_pkg::val_t in_val;
    logic           accept;

    assign in_seg = s_tdata[1:0];
    assign in_ci  = s_tdata[3:2];
    assign in_cnt = s_tdata[6:4];
    assign in_val = s_tdata[62:7];

    // Configuration and table storage.
    logic               enable_reg;
    logic [2:0]         segcnt_reg;
    pwpc_pkg::val_t     coef_reg  [TBL_D];
    pwpc_pkg::val_t     bound_reg [MAX_SEGMENTS];
    logic [CNT_W-1:0]   cnt_reg   [MAX_SEGMENTS];

    // Sequencer registers.
    logic [3:0]       state_reg, state_next;
    logic [1:0]       cmd_reg, cmd_next;
    pwpc_pkg::val_t   v_reg, v_next;
    logic [SEG_W-1:0] s_reg, s_next;
    logic [COEF_W-1:0] k_reg, k_next;
    pwpc_pkg::val_t   p_reg, p_next;
    pwpc_pkg::val_t   pd_reg, pd_next;
    pwpc_pkg::val_t   tmp_reg, tmp_next;
    pwpc_pkg::val_t   x_reg, x_next;
    logic [IT_W-1:0]  it_reg, it_next;
    logic [1:0]       after_reg, after_next;
    logic             deriv_reg, deriv_next;
    pwpc_pkg::val_t   res_reg, res_next;
    logic [1:0]       status_reg, status_next;
    logic             m_valid_reg, m_valid_next;
    pwpc_pkg::val_t   out_val_reg, out_val_next;
    logic [1:0]       out_status_reg, out_status_next;

    // Shared arithmetic units.
    pwpc_pkg::op_req_t mul_req, div_req;
    logic              mul_done, div_done;
    pwpc_pkg::val_t    mul_prod, div_quot;

    pwpc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mul_req),
        .done (mul_done),
        .prod (mul_prod)
    );

    pwpc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .done (div_done),
        .quot (div_quot)
    );

    // Table read port and derived values.
    logic [NS_W-1:0]   ns;
    logic              last_seg;
    logic [COEF_W-1:0] idx;
    logic [TBL_W-1:0]  coef_addr;
    pwpc_pkg::val_t    coef_rd;
    pwpc_pkg::val_t    bound_rd;
    logic [CNT_W-1:0]  cur_cnt;
    pwpc_pkg::val_t    diff;
    pwpc_pkg::val_t    ch_upd;
    logic              load_out;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign ns       = (int'(segcnt_reg) > MAX_SEGMENTS) ? NS_W'(MAX_SEGMENTS)
                                                        : NS_W'(segcnt_reg);
    assign last_seg = (int'(s_reg) == int'(ns) - 1);
    assign cur_cnt  = cnt_reg[s_reg];
    assign bound_rd = bound_reg[s_reg];
    assign diff     = pwpc_pkg::sat_sub(p_reg, v_reg);
    assign ch_upd   = pwpc_pkg::sat_sub(x_reg, div_quot);
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    // Coefficient index within the current segment for the single read port.
    always_comb
    begin
        priority case (state_reg)
            S_H_START: idx = COEF_W'(int'(cur_cnt) - 1);
            S_PICK:    idx = COEF_W'(1);
            S_GUESS:   idx = '0;
            default:   idx = k_reg;
        endcase
        coef_addr = TBL_W'(int'(s_reg) * MAX_COEFFS + int'(idx));
        coef_rd   = coef_reg[coef_addr];
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        v_next          = v_reg;
        s_next          = s_reg;
        k_next          = k_reg;
        p_next          = p_reg;
        pd_next         = pd_reg;
        tmp_next        = tmp_reg;
        x_next          = x_reg;
        it_next         = it_reg;
        after_next      = after_reg;
        deriv_next      = deriv_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        mul_req         = '{start: 1'b0, a: x_reg, b: p_reg};
        div_req         = '{start: 1'b0, a: diff, b: pd_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = s_tuser;
                    v_next      = in_val;
                    s_next      = '0;
                    res_next    = '0;
                    status_next = pwpc_pkg::STATUS_OK;
                    state_next  = S_DONE;
                    if (s_tuser != pwpc_pkg::CMD_LOAD_COEFF &&
                        s_tuser != pwpc_pkg::CMD_LOAD_BOUND)
                    begin
                        if (!enable_reg || ns == '0)
                            res_next = in_val;
                        else
                            state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (cmd_reg == pwpc_pkg::CMD_CH_TO_EN)
                begin
                    if (v_reg <= bound_rd || last_seg)
                    begin
                        if (cur_cnt == '0)
                        begin
                            res_next   = v_reg;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            x_next     = v_reg;
                            deriv_next = 1'b0;
                            after_next = AF_FWD;
                            state_next = S_H_START;
                        end
                    end
                    else
                        s_next = s_reg + 1'b1;
                end
                else
                begin
                    if (cur_cnt == '0)
                    begin
                        if (last_seg)
                            state_next = S_PICK;
                        else
                            s_next = s_reg + 1'b1;
                    end
                    else
                    begin
                        x_next     = bound_rd;
                        deriv_next = 1'b0;
                        after_next = AF_SEL;
                        state_next = S_H_START;
                    end
                end
            end

            S_H_START:
            begin
                p_next  = coef_rd;
                pd_next = '0;
                if (int'(cur_cnt) <= 1)
                    state_next = S_H_END;
                else
                begin
                    k_next     = COEF_W'(int'(cur_cnt) - 2);
                    state_next = deriv_reg ? S_H_DMUL : S_H_PMUL;
                end
            end

            S_H_DMUL:
            begin
                mul_req    = '{start: 1'b1, a: x_reg, b: pd_reg};
                state_next = S_H_DWAIT;
            end

            S_H_DWAIT:
            begin
                if (mul_done)
                begin
                    tmp_next   = mul_prod;
                    state_next = S_H_PMUL;
                end
            end

            S_H_PMUL:
            begin
                mul_req    = '{start: 1'b1, a: x_reg, b: p_reg};
                state_next = S_H_PWAIT;
            end

            S_H_PWAIT:
            begin
                if (mul_done)
                begin
                    if (deriv_reg)
                        pd_next = pwpc_pkg::sat_add(p_reg, tmp_reg);
                    p_next = pwpc_pkg::sat_add(coef_rd, mul_prod);
                    if (k_reg == '0)
                        state_next = S_H_END;
                    else
                    begin
                        k_next     = k_reg - 1'b1;
                        state_next = deriv_reg ? S_H_DMUL : S_H_PMUL;
                    end
                end
            end

            S_H_END:
            begin
                priority case (after_reg)
                    AF_FWD:
                    begin
                        res_next   = p_reg;
                        state_next = S_DONE;
                    end
                    AF_SEL:
                    begin
                        if (v_reg <= p_reg || last_seg)
                            state_next = S_PICK;
                        else
                        begin
                            s_next     = s_reg + 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                        state_next = S_CHECK;
                endcase
            end

            // Segment chosen for the inverse: handle the degenerate counts, fetch the slope.
            S_PICK:
            begin
                if (cur_cnt == '0)
                begin
                    res_next   = v_reg;
                    state_next = S_DONE;
                end
                else if (int'(cur_cnt) == 1)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    tmp_next   = coef_rd;
                    state_next = S_GUESS;
                end
            end

            // Linear starting guess, or the energy itself for a zero slope.
            S_GUESS:
            begin
                it_next    = '0;
                deriv_next = 1'b1;
                after_next = AF_NEWTON;
                if (tmp_reg != '0)
                begin
                    div_req    = '{start: 1'b1, a: pwpc_pkg::sat_sub(v_reg, coef_rd),
                                   b: tmp_reg};
                    state_next = S_GUESS_WT;
                end
                else
                begin
                    x_next     = v_reg;
                    state_next = S_H_START;
                end
            end

            S_GUESS_WT:
            begin
                if (div_done)
                begin
                    x_next     = div_quot;
                    state_next = S_H_START;
                end
            end

            // Convergence and zero-derivative tests, then the Newton division.
            S_CHECK:
            begin
                if (diff > -W'(2) && diff < W'(2))
                begin
                    res_next   = x_reg;
                    state_next = S_DONE;
                end
                else if (pd_reg == '0)
                begin
                    res_next    = x_reg;
                    status_next = pwpc_pkg::STATUS_ZERO_DERIV;
                    state_next  = S_DONE;
                end
                else
                begin
                    div_req    = '{start: 1'b1, a: diff, b: pd_reg};
                    state_next = S_NDIV_WT;
                end
            end

            S_NDIV_WT:
            begin
                if (div_done)
                begin
                    x_next  = ch_upd;
                    it_next = it_reg + 1'b1;
                    if (int'(it_reg) + 1 == NEWTON_ITERS)
                    begin
                        res_next    = ch_upd;
                        status_next = pwpc_pkg::STATUS_LIMIT;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_H_START;
                end
            end

            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Output register.
    always_comb
    begin
        m_valid_next    = m_valid_reg;
        out_val_next    = out_val_reg;
        out_status_next = out_status_reg;
        if (load_out)
        begin
            m_valid_next    = 1'b1;
            out_val_next    = res_reg;
            out_status_next = status_reg;
        end
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    // Control registers, configuration and coefficient counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmd_reg     <= pwpc_pkg::CMD_LOAD_COEFF;
            s_reg       <= '0;
            k_reg       <= '0;
            it_reg      <= '0;
            after_reg   <= AF_FWD;
            deriv_reg   <= 1'b0;
            status_reg  <= pwpc_pkg::STATUS_OK;
            m_valid_reg <= 1'b0;
            enable_reg  <= 1'b0;
            segcnt_reg  <= 3'd0;
            for (int i = 0; i < MAX_SEGMENTS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            s_reg       <= s_next;
            k_reg       <= k_next;
            it_reg      <= it_next;
            after_reg   <= after_next;
            deriv_reg   <= deriv_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pwpc_pkg::REG_ENABLE:    enable_reg <= cfg_data[0];
                    pwpc_pkg::REG_SEG_COUNT: segcnt_reg <= cfg_data;
                    default:                 enable_reg <= enable_reg;
                endcase
            end
            if (accept && s_tuser == pwpc_pkg::CMD_LOAD_BOUND && int'(in_seg) < MAX_SEGMENTS)
                cnt_reg[SEG_W'(in_seg)] <= (int'(in_cnt) < MAX_COEFFS) ? CNT_W'(in_cnt)
                                                                       : CNT_W'(MAX_COEFFS);
        end
    end

    // Payload registers and tables.
    always_ff @(posedge clk)
    begin
        v_reg          <= v_next;
        p_reg          <= p_next;
        pd_reg         <= pd_next;
        tmp_reg        <= tmp_next;
        x_reg          <= x_next;
        res_reg        <= res_next;
        out_val_reg    <= out_val_next;
        out_status_reg <= out_status_next;
        if (accept && s_tuser == pwpc_pkg::CMD_LOAD_COEFF &&
            int'(in_seg) < MAX_SEGMENTS && int'(in_ci) < MAX_COEFFS)
            coef_reg[TBL_W'(int'(in_seg) * MAX_COEFFS + int'(in_ci))] <= in_val;
        if (accept && s_tuser == pwpc_pkg::CMD_LOAD_BOUND && int'(in_seg) < MAX_SEGMENTS)
            bound_reg[SEG_W'(in_seg)] <= in_val;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_status_reg;

    // A non-zero status only ever comes from an inverse conversion.
    a_status_inverse: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status_reg != pwpc_pkg::STATUS_OK)
        |-> cmd_reg == pwpc_pkg::CMD_EN_TO_CH)
        else $error("non-zero status on a non-inverse item");

    // The Newton step counter never passes its limit.
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(it_reg) <= NEWTON_ITERS)
        else $error("Newton step counter overran");

    // A division is only started on the way into one of the division wait states.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> (state_reg == S_GUESS_WT || state_reg == S_NDIV_WT))
        else $error("division started outside a wait sequence");

    // The multiplier result is only consumed in a multiply wait state.
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_H_DWAIT || state_reg == S_H_PWAIT))
        else $error("multiplier finished with no consumer");

endmodule
